/* rtl/pmtsp_pkg.sv */
// shared types and constants of the program map section entry parser
// no dependencies; used by core, queue and top through scoped names
package pmtsp_pkg;

  localparam int unsigned SKIP_COUNT_BITS_DEF = 12;
  localparam int unsigned LEN_FIELD_BITS      = 12;
  localparam int unsigned RES_FIFO_DEPTH      = 4;

  localparam logic [7:0] EXPECTED_ID_RESET = 8'h02;
  localparam logic [4:0] PID_HIGH_MASK     = 5'h1F;
  localparam logic [3:0] LEN_HIGH_MASK     = 4'h0F;
  localparam logic [2:0] ENTRY_FIXED_BYTES = 3'd5;
  localparam logic [2:0] HEADER_BYTES      = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PCR    = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_HEADER     = 3'd1,
    PH_PROG_SKIP  = 3'd2,
    PH_ENTRY      = 3'd3,
    PH_ENTRY_SKIP = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [12:0] pid_value;
    logic [7:0]  stream_type;
    logic [7:0]  entry_number;
    logic        truncated;
    logic        end_of_run;
  } result_t;

endpackage

/* rtl/pmtsp_ifs.sv */
// valid/ready channel interfaces of the section parser
// byte input, result output and the table id write port; no dependencies
interface pmtsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic [7:0] section_table_id;

  modport source (output valid, data_byte, first_byte, last_byte, section_table_id,
                  input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, section_table_id,
                output ready);
endinterface

interface pmtsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [12:0] pid_value;
  logic [7:0]  stream_type;
  logic [7:0]  entry_number;
  logic        truncated;
  logic        end_of_run;

  modport source (output valid, result_kind, pid_value, stream_type, entry_number,
                  truncated, end_of_run, input ready);
  modport sink (input valid, result_kind, pid_value, stream_type, entry_number,
                truncated, end_of_run, output ready);
endinterface

interface pmtsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/pmtsp_core.sv */
// section parsing state machine: one byte per transfer, up to two results
// depends on pmtsp_pkg
module pmtsp_core #(
  parameter int unsigned SKIP_COUNT_BITS = pmtsp_pkg::SKIP_COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic [7:0]         section_table_id,
  input  logic [7:0]         expected_id,
  output logic [1:0]         res_cnt,
  output pmtsp_pkg::result_t res0,
  output pmtsp_pkg::result_t res1
);

  localparam int unsigned LB = pmtsp_pkg::LEN_FIELD_BITS;

  pmtsp_pkg::phase_t          phase_r, phase_nxt;
  logic [2:0]                 bif_r, bif_nxt;
  logic [SKIP_COUNT_BITS-1:0] skip_r, skip_nxt;
  logic [7:0]                 stype_r, stype_nxt;
  logic [4:0]                 pidh_r, pidh_nxt;
  logic [3:0]                 lenh_r, lenh_nxt;
  logic [7:0]                 cnt_r, cnt_nxt;

  logic [LB-1:0]              len12;
  logic [SKIP_COUNT_BITS-1:0] skip_len;
  pmtsp_pkg::result_t         rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pmtsp_pkg::PH_IDLE;
      bif_r   <= '0;
      skip_r  <= '0;
      cnt_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // held bytes are always written before they are read within a section
  always_ff @(posedge clk) begin
    if (take) begin
      stype_r <= stype_nxt;
      pidh_r  <= pidh_nxt;
      lenh_r  <= lenh_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bif_nxt   = bif_r;
    skip_nxt  = skip_r;
    stype_nxt = stype_r;
    pidh_nxt  = pidh_r;
    lenh_nxt  = lenh_r;
    cnt_nxt   = cnt_r;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    rec       = '0;

    len12 = {lenh_r, data_byte};
    // saturate a length that is wider than the skip counter
    if ((LB > SKIP_COUNT_BITS) && ((len12 >> SKIP_COUNT_BITS) != '0)) begin
      skip_len = '1;
    end else begin
      skip_len = SKIP_COUNT_BITS'(len12);
    end

    if (first_byte) begin
      phase_nxt = pmtsp_pkg::PH_HEADER;
      bif_nxt   = '0;
      skip_nxt  = '0;
      cnt_nxt   = '0;
      if (section_table_id != expected_id) begin
        rec             = '0;
        rec.result_kind = pmtsp_pkg::KIND_REJECT;
        res0            = rec;
        res_cnt         = 2'd1;
        phase_nxt       = pmtsp_pkg::PH_IDLE;
      end
    end

    if (phase_nxt != pmtsp_pkg::PH_IDLE) begin
      case (phase_nxt)
        pmtsp_pkg::PH_HEADER: begin
          case (bif_nxt)
            3'd0: begin
              pidh_nxt = data_byte[4:0] & pmtsp_pkg::PID_HIGH_MASK;
              bif_nxt  = 3'd1;
            end
            3'd1: begin
              rec             = '0;
              rec.result_kind = pmtsp_pkg::KIND_PCR;
              rec.pid_value   = {pidh_r, data_byte};
              res0            = rec;
              res_cnt         = 2'd1;
              bif_nxt         = 3'd2;
            end
            3'd2: begin
              lenh_nxt = data_byte[3:0] & pmtsp_pkg::LEN_HIGH_MASK;
              bif_nxt  = pmtsp_pkg::HEADER_BYTES - 3'd1;
            end
            default: begin
              skip_nxt  = skip_len;
              phase_nxt = (skip_len != '0) ? pmtsp_pkg::PH_PROG_SKIP : pmtsp_pkg::PH_ENTRY;
              bif_nxt   = '0;
            end
          endcase
        end
        pmtsp_pkg::PH_ENTRY: begin
          case (bif_nxt)
            3'd0: begin
              stype_nxt = data_byte;
              bif_nxt   = 3'd1;
            end
            3'd1: begin
              pidh_nxt = data_byte[4:0] & pmtsp_pkg::PID_HIGH_MASK;
              bif_nxt  = 3'd2;
            end
            3'd2: begin
              rec              = '0;
              rec.result_kind  = pmtsp_pkg::KIND_ENTRY;
              rec.pid_value    = {pidh_r, data_byte};
              rec.stream_type  = stype_r;
              rec.entry_number = cnt_r;
              res0             = rec;
              res_cnt          = 2'd1;
              if (cnt_r != 8'hFF) begin
                cnt_nxt = cnt_r + 8'd1;
              end
              bif_nxt = 3'd3;
            end
            3'd3: begin
              lenh_nxt = data_byte[3:0] & pmtsp_pkg::LEN_HIGH_MASK;
              bif_nxt  = pmtsp_pkg::ENTRY_FIXED_BYTES - 3'd1;
            end
            default: begin
              skip_nxt  = skip_len;
              phase_nxt = (skip_len != '0) ? pmtsp_pkg::PH_ENTRY_SKIP : pmtsp_pkg::PH_ENTRY;
              bif_nxt   = '0;
            end
          endcase
        end
        default: begin
          // descriptor loops of the program or of an entry
          if (skip_nxt != '0) begin
            skip_nxt = skip_nxt - 1'b1;
          end
          if (skip_nxt == '0) begin
            phase_nxt = pmtsp_pkg::PH_ENTRY;
            bif_nxt   = '0;
          end
        end
      endcase

      if (last_byte) begin
        rec              = '0;
        rec.result_kind  = pmtsp_pkg::KIND_DONE;
        rec.entry_number = cnt_nxt;
        rec.truncated    = !((phase_nxt == pmtsp_pkg::PH_ENTRY) && (bif_nxt == 3'd0));
        if (res_cnt == 2'd0) begin
          res0 = rec;
        end else begin
          res1 = rec;
        end
        res_cnt   = res_cnt + 2'd1;
        phase_nxt = pmtsp_pkg::PH_IDLE;
        bif_nxt   = '0;
      end
    end

    if (res_cnt == 2'd1) begin
      res0.end_of_run = 1'b1;
    end
    if (res_cnt == 2'd2) begin
      res1.end_of_run = 1'b1;
    end
  end

  // skip phases are entered only with a nonzero count
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == pmtsp_pkg::PH_PROG_SKIP || phase_r == pmtsp_pkg::PH_ENTRY_SKIP)
      |-> (skip_r != '0))
    else $error("skip phase with zero count");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !first_byte && phase_r == pmtsp_pkg::PH_IDLE) |-> (res_cnt == 2'd0))
    else $error("result from a byte outside a section");

  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (res0.result_kind != pmtsp_pkg::KIND_REJECT
                           && res1.result_kind == pmtsp_pkg::KIND_DONE))
    else $error("bad result pair");

  a_reject_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_cnt != 2'd0 && res0.result_kind == pmtsp_pkg::KIND_REJECT)
      |=> (phase_r == pmtsp_pkg::PH_IDLE))
    else $error("rejected section left open");

endmodule

/* rtl/pmtsp_res_fifo.sv */
// small result queue: up to two writes and one read per cycle
// depends on pmtsp_pkg
module pmtsp_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  pmtsp_pkg::result_t push0,
  input  pmtsp_pkg::result_t push1,
  input  logic               pop,
  output logic               room2,
  output logic               not_empty,
  output pmtsp_pkg::result_t head
);

  localparam int unsigned DEPTH = pmtsp_pkg::RES_FIFO_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  pmtsp_pkg::result_t slot_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      slot_r[wr_ptr_p1] <= push1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room2)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("result queue underflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd0 && !pop) |=> $stable(count_r))
    else $error("queue count moved without traffic");

endmodule

/* rtl/pmt_section_entry_parser.sv */
// program map section entry parser: one section byte per transfer
// a result is written to the result queue and read out from its head
// throughput one byte per cycle while the queue has room for two results;
// a byte that causes two results fills two slots of the 4-entry queue
// rst_n is synchronous: parser idles, queue empties, table id returns to 0x02
module pmt_section_entry_parser #(
  parameter int unsigned SKIP_COUNT_BITS = pmtsp_pkg::SKIP_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pmtsp_in_if.sink    in_ch,
  pmtsp_out_if.source out_ch,
  pmtsp_cfg_if.sink   cfg_ch
);

  logic [7:0]         exp_id_r;
  logic               take;
  logic               pop;
  logic               room2;
  logic               not_empty;
  logic [1:0]         res_cnt;
  pmtsp_pkg::result_t res0;
  pmtsp_pkg::result_t res1;
  pmtsp_pkg::result_t head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r <= pmtsp_pkg::EXPECTED_ID_RESET;
    end else if (cfg_ch.valid) begin
      exp_id_r <= cfg_ch.data;
    end
  end

  // accept only while the queue can hold the two results a byte may cause
  assign in_ch.ready = room2;
  assign take        = in_ch.valid && room2;
  assign pop         = out_ch.ready && not_empty;

  pmtsp_core #(
    .SKIP_COUNT_BITS (SKIP_COUNT_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .data_byte        (in_ch.data_byte),
    .first_byte       (in_ch.first_byte),
    .last_byte        (in_ch.last_byte),
    .section_table_id (in_ch.section_table_id),
    .expected_id      (exp_id_r),
    .res_cnt          (res_cnt),
    .res0             (res0),
    .res1             (res1)
  );

  pmtsp_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (take ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (pop),
    .room2     (room2),
    .not_empty (not_empty),
    .head      (head)
  );

  assign out_ch.valid        = not_empty;
  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.pid_value    = head.pid_value;
  assign out_ch.stream_type  = head.stream_type;
  assign out_ch.entry_number = head.entry_number;
  assign out_ch.truncated    = head.truncated;
  assign out_ch.end_of_run   = head.end_of_run;

  a_in_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == room2)
    else $error("input ready does not follow queue room");

  a_out_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_cnt != 2'd0) |=> out_ch.valid)
    else $error("result lost after byte transfer");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_ch.valid) |-> $stable(exp_id_r))
    else $error("table id changed without a write");

endmodule
